[rtl/pwm_duty_cycle_meter_core_assert.svh]
// ----------------------------------------------------------------------------
// PWM duty-cycle meter assertion macros
// Concurrent assertion shorthands, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PWM_DUTY_CYCLE_METER_CORE_ASSERT_SVH
`define PWM_DUTY_CYCLE_METER_CORE_ASSERT_SVH

// same-cycle implication
`define PDCM_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pdcm assertion failed");

// next-cycle implication
`define PDCM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pdcm assertion failed");

`endif

[rtl/pdcm_pkg.sv]
// ----------------------------------------------------------------------------
// PWM duty-cycle meter package
// Widths, constants and controller/datapath handshake types.
// ----------------------------------------------------------------------------
package pdcm_pkg;

	localparam int COUNT_WIDTH = 32;
	localparam int CAP_W       = 32;
	localparam int OUT_W       = 32;
	localparam int DUTY_W      = 17;
	localparam int PROD_W      = COUNT_WIDTH + DUTY_W;
	localparam int IDX_W       = $clog2(DUTY_W);

	localparam logic [DUTY_W-1:0] DUTY_FULL = DUTY_W'(100000);
	localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(DUTY_W - 1);

	typedef logic [COUNT_WIDTH-1:0] cnt_t;
	typedef logic [CAP_W-1:0]       cap_t;
	typedef logic [OUT_W-1:0]       out_t;
	typedef logic [DUTY_W-1:0]      duty_t;

	typedef struct packed {
		logic             take_rise;
		logic             take_fall;
		logic             take_second;
		logic             mul_clr;
		logic             mul_step;
		logic             div_init;
		logic             div_step;
		logic             load_out;
		logic [IDX_W-1:0] idx;
	} cmd_t;

	typedef struct packed {
		logic zero;
		logic sat;
	} sts_t;

endpackage

[rtl/pdcm_in_if.sv]
// ----------------------------------------------------------------------------
// Capture request channel
// Valid/ready channel carrying one latched timer count.
// ----------------------------------------------------------------------------
interface pdcm_in_if;
	import pdcm_pkg::*;

	logic valid;
	logic ready;
	cap_t capture_time;

	modport source (output valid, output capture_time, input ready);
	modport sink   (input valid, input capture_time, output ready);
endinterface

[rtl/pdcm_out_if.sv]
// ----------------------------------------------------------------------------
// Measurement result channel
// Valid/ready channel carrying high time, period and duty.
// ----------------------------------------------------------------------------
interface pdcm_out_if;
	import pdcm_pkg::*;

	logic  valid;
	logic  ready;
	out_t  high_time;
	out_t  period_ticks;
	duty_t duty_milli_percent;
	logic  zero_period;

	modport source (output valid, output high_time, output period_ticks,
		output duty_milli_percent, output zero_period, input ready);
	modport sink   (input valid, input high_time, input period_ticks,
		input duty_milli_percent, input zero_period, output ready);
endinterface

[rtl/pdcm_dp.sv]
// ----------------------------------------------------------------------------
// PWM duty-cycle meter datapath
// Timestamp store, shift-add scale by 100000, restoring divide, result regs.
// ----------------------------------------------------------------------------
module pdcm_dp (
	input  logic             clk,
	input  pdcm_pkg::cap_t   capture_time,
	input  pdcm_pkg::cmd_t   cmd,
	output pdcm_pkg::sts_t   sts,
	output pdcm_pkg::out_t   high_time,
	output pdcm_pkg::out_t   period_ticks,
	output pdcm_pkg::duty_t  duty_milli_percent,
	output logic             zero_period
);
	import pdcm_pkg::*;

	cnt_t                    t;
	cnt_t                    rise_q;
	cnt_t                    fall_q;
	cnt_t                    high_q;
	cnt_t                    per_q;
	logic [PROD_W-1:0]       prod_q;
	logic [PROD_W-1:0]       addend;
	cnt_t                    rem_q;
	logic [COUNT_WIDTH:0]    trial;
	logic                    fits;
	duty_t                   lsb_q;
	duty_t                   quo_q;
	duty_t                   duty;
	out_t                    high_out_q;
	out_t                    per_out_q;
	duty_t                   duty_out_q;
	logic                    zero_out_q;

	assign t        = cnt_t'(capture_time);
	assign sts.zero = (per_q == '0);
	assign sts.sat  = (high_q >= per_q);

	assign addend = DUTY_FULL[cmd.idx] ? (PROD_W'(high_q) << cmd.idx) : '0;
	assign trial  = {rem_q, lsb_q[DUTY_W-1]};
	assign fits   = (trial >= {1'b0, per_q});

	always_comb begin
		if (sts.zero) begin
			duty = '0;
		end else if (sts.sat) begin
			duty = DUTY_FULL;
		end else begin
			duty = quo_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_rise) begin
			rise_q <= t;
		end
		if (cmd.take_fall) begin
			fall_q <= t;
		end
		if (cmd.take_second) begin
			high_q <= fall_q - rise_q;
			per_q  <= t - rise_q;
		end
		if (cmd.mul_clr) begin
			prod_q <= '0;
		end else if (cmd.mul_step) begin
			prod_q <= prod_q + addend;
		end
		if (cmd.div_init) begin
			rem_q <= prod_q[PROD_W-1:DUTY_W];
			lsb_q <= prod_q[DUTY_W-1:0];
			quo_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= fits ? COUNT_WIDTH'(trial - {1'b0, per_q}) : trial[COUNT_WIDTH-1:0];
			lsb_q <= {lsb_q[DUTY_W-2:0], 1'b0};
			quo_q <= {quo_q[DUTY_W-2:0], fits};
		end
		if (cmd.load_out) begin
			high_out_q <= out_t'(high_q);
			per_out_q  <= out_t'(per_q);
			duty_out_q <= duty;
			zero_out_q <= sts.zero;
		end
	end

	assign high_time          = high_out_q;
	assign period_ticks       = per_out_q;
	assign duty_milli_percent = duty_out_q;
	assign zero_period        = zero_out_q;

endmodule

[rtl/pdcm_ctrl.sv]
// ----------------------------------------------------------------------------
// PWM duty-cycle meter controller
// Edge phase tracking, multiply/divide sequencing and result valid.
// ----------------------------------------------------------------------------
module pdcm_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_vld,
	output logic           in_rdy,
	output logic           out_vld,
	input  logic           out_rdy,
	input  pdcm_pkg::sts_t sts,
	output pdcm_pkg::cmd_t cmd
);
	import pdcm_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_CHK   = 6'b000010,
		S_MUL   = 6'b000100,
		S_DINIT = 6'b001000,
		S_DIV   = 6'b010000,
		S_OUT   = 6'b100000
	} state_t;

	typedef enum logic [1:0] {
		PH_RISE   = 2'd0,
		PH_FALL   = 2'd1,
		PH_SECOND = 2'd2
	} phase_t;

	state_t           state_q, state_d;
	phase_t           phase_q, phase_d;
	logic [IDX_W-1:0] cnt_q, cnt_d;
	logic             out_vld_q, out_vld_d;
	logic             in_acc;
	logic             out_room;

	assign in_rdy   = (state_q == S_IDLE);
	assign in_acc   = in_vld && in_rdy;
	assign out_room = !out_vld_q || out_rdy;
	assign out_vld  = out_vld_q;

	always_comb begin
		state_d = state_q;
		phase_d = phase_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		cmd.idx = cnt_q;
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					case (phase_q)
						PH_FALL: begin
							cmd.take_fall = 1'b1;
							phase_d       = PH_SECOND;
						end
						PH_SECOND: begin
							cmd.take_second = 1'b1;
							phase_d         = PH_RISE;
							state_d         = S_CHK;
						end
						default: begin
							cmd.take_rise = 1'b1;
							phase_d       = PH_FALL;
						end
					endcase
				end
			end
			S_CHK: begin
				cnt_d = '0;
				if (sts.zero || sts.sat) begin
					state_d = S_OUT;
				end else begin
					cmd.mul_clr = 1'b1;
					state_d     = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul_step = 1'b1;
				if (cnt_q == IDX_LAST) begin
					state_d = S_DINIT;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			S_DINIT: begin
				cmd.div_init = 1'b1;
				cnt_d        = '0;
				state_d      = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == IDX_LAST) begin
					state_d = S_OUT;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			S_OUT: begin
				if (out_room) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		if (cmd.load_out) begin
			out_vld_d = 1'b1;
		end else if (out_rdy) begin
			out_vld_d = 1'b0;
		end else begin
			out_vld_d = out_vld_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			phase_q   <= PH_RISE;
			cnt_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			phase_q   <= phase_d;
			cnt_q     <= cnt_d;
			out_vld_q <= out_vld_d;
		end
	end

`include "pwm_duty_cycle_meter_core_assert.svh"

	`PDCM_ASSERT_NEXT(a_third_edge_starts, in_acc && (phase_q == PH_SECOND), (state_q == S_CHK) && (phase_q == PH_RISE))
	`PDCM_ASSERT_NOW(a_cnt_in_range, (state_q == S_MUL) || (state_q == S_DIV), cnt_q <= IDX_LAST)
	`PDCM_ASSERT_NOW(a_result_from_out, $rose(out_vld_q), $past(state_q == S_OUT))
	`PDCM_ASSERT_NEXT(a_out_delivers, (state_q == S_OUT) && out_room, out_vld_q && (state_q == S_IDLE))

endmodule

[rtl/pwm_duty_cycle_meter_core.sv]
// ----------------------------------------------------------------------------
// PWM duty-cycle meter
// Input-capture duty measurement from rising, falling, rising timestamps.
// ----------------------------------------------------------------------------
// Each capture request carries the timer count of the next edge, in the
// order rising, falling, rising. The first two requests are stored as they
// are taken. The third starts the measurement: high time and period are
// formed at once, the high time is scaled by 100000 in a shift-add
// multiplier and divided by the period in a restoring divider, and the
// result is loaded into the output register. A zero period or a high time
// not below the period skips both units. Capture requests are taken only
// while no measurement is in progress; a finished result waits in the
// output register without blocking new edges.
// ----------------------------------------------------------------------------
module pwm_duty_cycle_meter_core (
	input  logic              clk,
	input  logic              arst_n,
	pdcm_in_if.sink           capture,
	pdcm_out_if.source        result
);
	import pdcm_pkg::*;

	cmd_t cmd;
	sts_t sts;

	pdcm_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (capture.valid),
		.in_rdy  (capture.ready),
		.out_vld (result.valid),
		.out_rdy (result.ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	pdcm_dp u_dp (
		.clk                (clk),
		.capture_time       (capture.capture_time),
		.cmd                (cmd),
		.sts                (sts),
		.high_time          (result.high_time),
		.period_ticks       (result.period_ticks),
		.duty_milli_percent (result.duty_milli_percent),
		.zero_period        (result.zero_period)
	);

endmodule
